FILE: hdl/signed_int_to_decimal_ascii_top_assert.svh
// assertion macros shared by the signed integer to decimal text block
// depends on clk and rst_n being visible where the macros are used
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SITDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sitda_pkg.sv
// shared types and constants for the signed integer to decimal text block
// no dependencies
package sitda_pkg;

  // field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 6;

  // decimal digit storage: ten digits cover a 32-bit magnitude
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;

  // widths of the sequencing counters
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
  localparam int unsigned DIG_CNT_W = $clog2(NUM_DIGITS + 1);

  // character codes, already cut to the six-bit output field
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // control sequence
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGS
  } state_t;

endpackage

FILE: hdl/signed_int_to_decimal_ascii_top.sv
// signed 32-bit integer to decimal ascii text, one character per output request
// depends on sitda_pkg and signed_int_to_decimal_ascii_top_assert.svh

// One request in gives the number's decimal text out, most significant digit
// first, a leading '-' for negative values, no leading zeros, and last_char set
// on the final character. The magnitude is turned into ten decimal digits by a
// bit-serial shift-and-add-3 converter, one binary bit per cycle, and the
// digits are then shifted out one per cycle while the output is not stalled,
// leading zeros dropped on the way. An item goes through the request take, the
// conversion of every input bit, the sign for a negative value and the ten
// digit positions, skipped or emitted; a stalled output holds the sign and the
// emitted digits. One item is worked on at a time; the result register lets the
// final character wait while the next request is accepted.
`include "signed_int_to_decimal_ascii_top_assert.svh"

module signed_int_to_decimal_ascii_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sitda_pkg::CHAR_W-1:0]        out_text_char,
  output logic                                out_last_char
);

  sitda_pkg::state_t state_r, state_nxt;

  logic [sitda_pkg::VALUE_W-1:0]   mag_r, mag_nxt;
  logic [sitda_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [sitda_pkg::BCD_W-1:0]     bcd_adj;
  logic [sitda_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [sitda_pkg::DIG_CNT_W-1:0] dig_left_r, dig_left_nxt;
  logic                            neg_r, neg_nxt;
  logic                            started_r, started_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [sitda_pkg::CHAR_W-1:0]    char_r, char_nxt;
  logic                            last_r, last_nxt;

  logic [3:0] top_digit;
  logic       slot_free;
  logic       conv_done;
  logic       skip_zero;
  logic       final_digit;

  // control produced by the sequencer
  logic in_take;
  logic conv_step;
  logic dig_step;
  logic load_sign;
  logic load_digit;

  assign top_digit   = bcd_r[sitda_pkg::BCD_W-1 -: 4];
  assign slot_free   = !out_valid_r || out_ready;
  assign conv_done   = (bit_cnt_r == sitda_pkg::BIT_CNT_W'(sitda_pkg::VALUE_W - 1));
  assign final_digit = (dig_left_r == sitda_pkg::DIG_CNT_W'(1));
  assign skip_zero   = (top_digit == 4'd0) && !started_r && !final_digit;

  // add-3 correction on every digit ahead of the shift
  always_comb begin
    for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sitda_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sitda_pkg::ST_CONV;
        end
      end
      sitda_pkg::ST_CONV: begin
        if (conv_done) begin
          state_nxt = neg_r ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGS;
        end
      end
      sitda_pkg::ST_SIGN: begin
        if (slot_free) begin
          state_nxt = sitda_pkg::ST_DIGS;
        end
      end
      sitda_pkg::ST_DIGS: begin
        if (!skip_zero && slot_free && final_digit) begin
          state_nxt = sitda_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sitda_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_take    = 1'b0;
    conv_step  = 1'b0;
    dig_step   = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    unique case (state_r)
      sitda_pkg::ST_IDLE: in_take   = in_valid;
      sitda_pkg::ST_CONV: conv_step = 1'b1;
      sitda_pkg::ST_SIGN: load_sign = slot_free;
      sitda_pkg::ST_DIGS: begin
        load_digit = !skip_zero && slot_free;
        dig_step   = skip_zero || slot_free;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    mag_nxt      = mag_r;
    bcd_nxt      = bcd_r;
    bit_cnt_nxt  = bit_cnt_r;
    dig_left_nxt = dig_left_r;
    neg_nxt      = neg_r;
    started_nxt  = started_r;
    if (in_take) begin
      neg_nxt      = in_value[sitda_pkg::VALUE_W-1];
      mag_nxt      = in_value[sitda_pkg::VALUE_W-1] ? (~in_value + 1'b1) : in_value;
      bcd_nxt      = '0;
      bit_cnt_nxt  = '0;
      dig_left_nxt = sitda_pkg::DIG_CNT_W'(sitda_pkg::NUM_DIGITS);
      started_nxt  = 1'b0;
    end else if (conv_step) begin
      bcd_nxt     = {bcd_adj[sitda_pkg::BCD_W-2:0], mag_r[sitda_pkg::VALUE_W-1]};
      mag_nxt     = {mag_r[sitda_pkg::VALUE_W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end else if (dig_step) begin
      bcd_nxt      = {bcd_r[sitda_pkg::BCD_W-5:0], 4'd0};
      dig_left_nxt = dig_left_r - 1'b1;
      started_nxt  = started_r || load_digit;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    char_nxt      = char_r;
    last_nxt      = last_r;
    if (load_sign) begin
      out_valid_nxt = 1'b1;
      char_nxt      = sitda_pkg::CHAR_MINUS;
      last_nxt      = 1'b0;
    end else if (load_digit) begin
      out_valid_nxt = 1'b1;
      char_nxt      = sitda_pkg::CHAR_ZERO + {2'b00, top_digit};
      last_nxt      = final_digit;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sitda_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      dig_left_r  <= '0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      dig_left_r  <= dig_left_nxt;
      started_r   <= started_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign in_ready      = (state_r == sitda_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_text_char = char_r;
  assign out_last_char = last_r;

  // checks on the sequencing
  `SITDA_ASSERT_NEXT(a_take_starts_conv, in_valid && in_ready,
    (state_r == sitda_pkg::ST_CONV) && (bit_cnt_r == '0), "request did not start conversion")
  `SITDA_ASSERT_NOW(a_sign_not_last, out_valid && (out_text_char == sitda_pkg::CHAR_MINUS),
    !out_last_char, "minus sign flagged as last character")
  `SITDA_ASSERT_NOW(a_last_is_digit, out_valid && out_last_char,
    (out_text_char >= sitda_pkg::CHAR_ZERO) && (out_text_char <= sitda_pkg::CHAR_NINE),
    "last character is not a digit")
  `SITDA_ASSERT_NOW(a_digits_left, state_r == sitda_pkg::ST_DIGS,
    dig_left_r != '0, "digit phase with no digits left")

endmodule

FILE: tb/sitda_text_checker.sv
`timescale 1ns / 100ps
// request watcher and character predictor for the signed integer to decimal text block
// depends on sitda_pkg for field widths and character codes

module sitda_text_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [sitda_pkg::CHAR_W-1:0]         out_text_char,
  input  logic                                 out_last_char,
  output int                                   mismatch_count,
  output int                                   chars_due,
  output int                                   chars_checked
);

  localparam int unsigned DEC_BASE = 10;

  typedef struct packed {
    logic [sitda_pkg::CHAR_W-1:0] text_char;
    logic                         last_char;
  } text_char_t;

  text_char_t due_q[$];

  // decimal text of one value, sign first, most significant digit first
  function automatic void push_decimal_text(input logic [sitda_pkg::VALUE_W-1:0] v);
    logic [sitda_pkg::VALUE_W:0] mag;
    logic [3:0]                  digs[sitda_pkg::NUM_DIGITS];
    int                          nd;
    text_char_t                  tc;
    mag = v[sitda_pkg::VALUE_W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    nd  = 0;
    do begin
      digs[nd] = 4'(mag % DEC_BASE);
      mag      = mag / DEC_BASE;
      nd++;
    end while (mag != 0 && nd < sitda_pkg::NUM_DIGITS);
    if (v[sitda_pkg::VALUE_W-1]) begin
      tc.text_char = sitda_pkg::CHAR_MINUS;
      tc.last_char = 1'b0;
      due_q.push_back(tc);
    end
    while (nd > 0) begin
      nd--;
      tc.text_char = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digs[nd]);
      tc.last_char = (nd == 0);
      due_q.push_back(tc);
    end
  endfunction

  // compare each character with the oldest prediction, then log new requests
  always @(posedge clk) begin
    text_char_t want;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      due_q.delete();
      mismatch_count <= 0;
      chars_checked  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        chars_checked <= chars_checked + 1;
        if (due_q.size() == 0) begin
          $error("unexpected character %0d last_char %0b with nothing due",
                 out_text_char, out_last_char);
          errs++;
        end else begin
          want = due_q.pop_front();
          if (want.text_char !== out_text_char) begin
            $error("text_char expected %0d actual %0d", want.text_char, out_text_char);
            errs++;
          end
          if (want.last_char !== out_last_char) begin
            $error("last_char expected %0b actual %0b", want.last_char, out_last_char);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        push_decimal_text(in_value);
      end
      mismatch_count <= mismatch_count + errs;
    end
    chars_due <= due_q.size();
  end

endmodule

FILE: tb/tb_signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 100ps
// top of the testbench for the signed integer to decimal text block: stimulus and verdict
// depends on sitda_pkg, signed_int_to_decimal_ascii_top and sitda_text_checker

module tb_signed_int_to_decimal_ascii_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS  = 74;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic signed [sitda_pkg::VALUE_W-1:0] in_value;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [sitda_pkg::CHAR_W-1:0]         out_text_char;
  logic                                 out_last_char;

  int mismatch_count;
  int chars_due;
  int chars_checked;

  int idle_pct = 0;
  int stall_pct = 0;
  int values_sent;
  int negatives_sent;
  int cycle_count = 0;

  signed_int_to_decimal_ascii_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  sitda_text_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_text_char  (out_text_char),
    .out_last_char  (out_last_char),
    .mismatch_count (mismatch_count),
    .chars_due      (chars_due),
    .chars_checked  (chars_checked)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // known values from time zero
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_value  = '0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still due", cycle_count, chars_due);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one request; starts and ends just after a falling edge
  task automatic send_value(input logic [sitda_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    values_sent++;
    if (v[sitda_pkg::VALUE_W-1]) negatives_sent++;
    @(negedge clk);
  endtask

  // hold off until every predicted character has come out
  task automatic drain_text();
    in_valid <= 1'b0;
    @(negedge clk);
    while (chars_due != 0) @(negedge clk);
  endtask

  // random value: mostly by digit count so short and long texts both show up
  function automatic logic [sitda_pkg::VALUE_W-1:0] pick_value();
    longint lo;
    longint hi;
    int     nd;
    logic [sitda_pkg::VALUE_W-1:0] v;
    if ($urandom_range(4) == 0) begin
      v = $urandom();
    end else if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'hFFFF_FFFF;
        default: v = '0;
      endcase
    end else begin
      nd = $urandom_range(10, 1);
      lo = 1;
      for (int i = 1; i < nd; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (nd == 1) lo = 0;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      v = $urandom_range(32'(hi), 32'(lo));
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  initial begin
    logic [sitda_pkg::VALUE_W-1:0] edge_vals[$];
    values_sent    = 0;
    negatives_sent = 0;

    // synchronous reset, released just after a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero, single digits, digit-count boundaries, extremes of the field
    edge_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                  32'd12345, -32'sd7, 32'd1000000000, -32'sd999999999,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1999999999};
    foreach (edge_vals[i]) send_value(edge_vals[i]);
    drain_text();

    // random in four flow-control phases, drained between phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_value(pick_value());
      drain_text();
    end

    // let any stray output show up
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("converted %0d values (%0d negative) into %0d checked characters",
             values_sent, negatives_sent, chars_checked);
    $display("flow control covered: free running, sender idling, receiver stalling, both");
    if (mismatch_count == 0 && chars_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
